/* rtl/epsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package epsd_pkg;

  // Field widths
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  // Internal widths
  localparam int unsigned DAYS_W = 16;  // days since epoch, at most 49710
  localparam int unsigned SOD_W  = 17;  // seconds of day, below 86400
  localparam int unsigned DOE_W  = 18;  // day of era, 0..146096
  localparam int unsigned YOE_W  = 9;   // year of era, 0..399
  localparam int unsigned DOY_W  = 9;   // March-based day of year, 0..365
  localparam int unsigned MP_W   = 4;   // March-based month, 0..11

  // Calendar constants
  localparam logic [SOD_W-1:0]  SECS_PER_DAY   = 17'd86400;
  localparam logic [19:0]       DAYS_TO_MARCH0 = 20'd719468;
  localparam logic [19:0]       ERA4_START     = 20'd584388;  // 4 * 146097
  localparam logic [19:0]       ERA5_START     = 20'd730485;  // 5 * 146097
  localparam logic [DOE_W-1:0]  DOE_CENT1      = 18'd36524;
  localparam logic [DOE_W-1:0]  DOE_CENT2      = 18'd73048;
  localparam logic [DOE_W-1:0]  DOE_CENT3      = 18'd109572;
  localparam logic [DOE_W-1:0]  DOE_LAST       = 18'd146096;
  localparam logic [YEAR_W-1:0] ERA4_YEAR      = 12'd1600;
  localparam logic [YEAR_W-1:0] ERA5_YEAR      = 12'd2000;

  // Reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s over each operand range
  localparam logic [25:0] RECIP_675   = 26'd50903317;  // s = 35, x < 2^25
  localparam int unsigned SHIFT_675   = 35;
  localparam logic [15:0] RECIP_365Q  = 16'd45965;     // s = 24, x < 36525
  localparam int unsigned SHIFT_365Q  = 24;
  localparam logic [17:0] RECIP_365   = 18'd183860;    // s = 26, x < 146097
  localparam int unsigned SHIFT_365   = 26;
  localparam logic [9:0]  RECIP_100   = 10'd656;       // s = 16, x < 400
  localparam int unsigned SHIFT_100   = 16;
  localparam logic [10:0] RECIP_153   = 11'd1714;      // s = 18, x < 1828
  localparam int unsigned SHIFT_153   = 18;
  localparam logic [12:0] RECIP_225   = 13'd4661;      // s = 20, x < 5400
  localparam int unsigned SHIFT_225   = 20;
  localparam logic [15:0] RECIP_15    = 16'd34953;     // s = 19, x < 21600
  localparam int unsigned SHIFT_15    = 19;

  // Pipeline depth
  localparam int unsigned SPLIT_STAGES = 2;
  localparam int unsigned CIVIL_STAGES = 8;
  localparam int unsigned TOD_STAGES   = 2;
  // The first delay register also holds the finished minute
  localparam int unsigned TOD_DELAY    = CIVIL_STAGES - TOD_STAGES + 1;
  localparam int unsigned LATENCY      = SPLIT_STAGES + CIVIL_STAGES;

  // Days split into whole days and seconds of day
  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
    logic [SOD_W-1:0]  sod;
  } split_out_t;

  // First day of each March-based month within the year: (153 * mp + 2) / 5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/epsd_split.sv */
`timescale 1ns / 1ps
`default_nettype none

module epsd_split import epsd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [EPOCH_W-1:0] epoch_seconds,
  output split_out_t              split_out
);

  // Stage A: days = t / 86400 = (t >> 7) / 675
  logic [50:0]        day_prod;
  logic               valid_a;
  logic [EPOCH_W-1:0] t_a;
  logic [DAYS_W-1:0]  days_a;

  // Stage B: seconds of day
  logic [32:0]        day_secs;
  logic [EPOCH_W-1:0] sod_wide;

  assign day_prod = 51'(epoch_seconds[EPOCH_W-1:7]) * 51'(RECIP_675);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
    t_a    <= epoch_seconds;
    days_a <= day_prod[SHIFT_675 +: DAYS_W];
  end

  assign day_secs = 33'(days_a) * 33'(SECS_PER_DAY);
  assign sod_wide = t_a - day_secs[EPOCH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      split_out.valid <= 1'b0;
    end else begin
      split_out.valid <= valid_a;
    end
    split_out.days <= days_a;
    split_out.sod  <= sod_wide[SOD_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/epsd_tod.sv */
`timescale 1ns / 1ps
`default_nettype none

module epsd_tod import epsd_pkg::*; (
  input  wire logic                clk,
  input  wire logic [SOD_W-1:0]    sod,
  output logic      [HOUR_W-1:0]   hour,
  output logic      [MINUTE_W-1:0] minute
);

  logic [25:0]         hour_prod;   // (sod >> 4) * RECIP_225
  logic [30:0]         mod_prod;    // (sod >> 2) * RECIP_15
  logic [HOUR_W-1:0]   hour_t1;
  logic [10:0]         mod_t1;      // minute of day, 0..1439
  logic [10:0]         hour_mins;
  logic [10:0]         minute_wide;
  logic [HOUR_W-1:0]   hour_dly   [TOD_DELAY];
  logic [MINUTE_W-1:0] minute_dly [TOD_DELAY];

  assign hour_prod = 26'(sod[SOD_W-1:4]) * 26'(RECIP_225);
  assign mod_prod  = 31'(sod[SOD_W-1:2]) * 31'(RECIP_15);

  always_ff @(posedge clk) begin
    hour_t1 <= hour_prod[SHIFT_225 +: HOUR_W];
    mod_t1  <= mod_prod[SHIFT_15 +: 11];
  end

  // minute = minute of day - 60 * hour
  assign hour_mins   = 11'(hour_t1) * 11'd60;
  assign minute_wide = mod_t1 - hour_mins;

  // Hold the time of day until the date catches up
  always_ff @(posedge clk) begin
    hour_dly[0]   <= hour_t1;
    minute_dly[0] <= minute_wide[MINUTE_W-1:0];
    for (int i = 1; i < TOD_DELAY; i++) begin
      hour_dly[i]   <= hour_dly[i-1];
      minute_dly[i] <= minute_dly[i-1];
    end
  end

  assign hour   = hour_dly[TOD_DELAY-1];
  assign minute = minute_dly[TOD_DELAY-1];

endmodule

`default_nettype wire

/* rtl/epsd_civil.sv */
`timescale 1ns / 1ps
`default_nettype none

module epsd_civil import epsd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [DAYS_W-1:0]  days,
  output logic                    out_valid,
  output logic      [YEAR_W-1:0]  year,
  output logic      [MONTH_W-1:0] month,
  output logic      [DAY_W-1:0]   day
);

  logic [CIVIL_STAGES-1:0] valid;

  // C0: shift to 0000-03-01 and pick the era (4 or 5 over the 32-bit range)
  logic [19:0]       z;
  logic              era_sel;
  logic [19:0]       doe_wide;
  logic              era0;
  logic [DOE_W-1:0]  doe0;

  // C1: leap corrections
  logic [31:0]       q1460_prod;
  logic [2:0]        q36524;
  logic              era1;
  logic [DOE_W-1:0]  doe1;
  logic [6:0]        q1460_1;
  logic [2:0]        q36524_1;
  logic              qlast1;

  // C2: corrected day count
  logic              era2;
  logic [DOE_W-1:0]  doe2;
  logic [DOE_W-1:0]  n2;

  // C3: year of era
  logic [35:0]       yoe_prod;
  logic              era3;
  logic [DOE_W-1:0]  doe3;
  logic [YOE_W-1:0]  yoe3;

  // C4: days before the year
  logic [18:0]       q100_prod;
  logic              era4;
  logic [DOE_W-1:0]  doe4;
  logic [YOE_W-1:0]  yoe4;
  logic [DOE_W-1:0]  yoe365_4;
  logic [1:0]        q100_4;

  // C5: day of year
  logic [DOE_W-1:0]  year_start;
  logic [DOE_W-1:0]  doy_wide;
  logic              era5;
  logic [YOE_W-1:0]  yoe5;
  logic [DOY_W-1:0]  doy5;

  // C6: March-based month
  logic [10:0]       mp_num;
  logic [21:0]       mp_prod;
  logic              era6;
  logic [YOE_W-1:0]  yoe6;
  logic [DOY_W-1:0]  doy6;
  logic [MP_W-1:0]   mp6;

  // C7: civil fields
  logic [DOY_W-1:0]   day_wide;
  logic [MONTH_W-1:0] month_next;
  logic [YEAR_W-1:0]  year_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[CIVIL_STAGES-2:0], in_valid};
    end
  end

  assign z        = 20'(days) + DAYS_TO_MARCH0;
  assign era_sel  = (z >= ERA5_START);
  assign doe_wide = era_sel ? (z - ERA5_START) : (z - ERA4_START);

  always_ff @(posedge clk) begin
    era0 <= era_sel;
    doe0 <= doe_wide[DOE_W-1:0];
  end

  assign q1460_prod = 32'(doe0[DOE_W-1:2]) * 32'(RECIP_365Q);

  always_comb begin
    if (doe0 >= DOE_LAST) begin
      q36524 = 3'd4;
    end else if (doe0 >= DOE_CENT3) begin
      q36524 = 3'd3;
    end else if (doe0 >= DOE_CENT2) begin
      q36524 = 3'd2;
    end else if (doe0 >= DOE_CENT1) begin
      q36524 = 3'd1;
    end else begin
      q36524 = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    era1     <= era0;
    doe1     <= doe0;
    q1460_1  <= q1460_prod[SHIFT_365Q +: 7];
    q36524_1 <= q36524;
    qlast1   <= (doe0 == DOE_LAST);
  end

  always_ff @(posedge clk) begin
    era2 <= era1;
    doe2 <= doe1;
    n2   <= doe1 - 18'(q1460_1) + 18'(q36524_1) - 18'(qlast1);
  end

  assign yoe_prod = 36'(n2) * 36'(RECIP_365);

  always_ff @(posedge clk) begin
    era3 <= era2;
    doe3 <= doe2;
    yoe3 <= yoe_prod[SHIFT_365 +: YOE_W];
  end

  assign q100_prod = 19'(yoe3) * 19'(RECIP_100);

  always_ff @(posedge clk) begin
    era4     <= era3;
    doe4     <= doe3;
    yoe4     <= yoe3;
    yoe365_4 <= 18'(yoe3) * 18'd365;
    q100_4   <= q100_prod[SHIFT_100 +: 2];
  end

  assign year_start = yoe365_4 + 18'(yoe4[YOE_W-1:2]) - 18'(q100_4);
  assign doy_wide   = doe4 - year_start;

  always_ff @(posedge clk) begin
    era5 <= era4;
    yoe5 <= yoe4;
    doy5 <= doy_wide[DOY_W-1:0];
  end

  assign mp_num  = 11'(doy5) * 11'd5 + 11'd2;
  assign mp_prod = 22'(mp_num) * 22'(RECIP_153);

  always_ff @(posedge clk) begin
    era6 <= era5;
    yoe6 <= yoe5;
    doy6 <= doy5;
    mp6  <= mp_prod[SHIFT_153 +: MP_W];
  end

  // Advance the year for January and February
  assign day_wide   = doy6 - month_start(mp6) + 9'd1;
  assign month_next = (mp6 < 4'd10) ? (mp6 + 4'd3) : (mp6 - 4'd9);
  assign year_next  = 12'(yoe6) + (era6 ? ERA5_YEAR : ERA4_YEAR)
                    + 12'(month_next <= 4'd2);

  always_ff @(posedge clk) begin
    year  <= year_next;
    month <= month_next;
    day   <= day_wide[DAY_W-1:0];
  end

  assign out_valid = valid[CIVIL_STAGES-1];

endmodule

`default_nettype wire

/* rtl/epoch_seconds_to_civil_date.sv */
// Channel   Handshake               Payload
// --------  ----------------------  ----------------------------------------
// command   start, busy (always 0)  epoch_seconds[31:0]
// result    done (one-cycle strobe) year[11:0] month[3:0] day[4:0]
//                                   hour[4:0] minute[5:0]
//
// One transaction enters every cycle; the result strobes on done after
// the 2 split stages and the 8 calendar stages, whose depth is set by the
// chain of reciprocal multiplies in the civil-from-days path.
// rst is synchronous, active high, and clears only the valid bits.
// The receiver cannot stall, so busy stays low and nothing is ever held.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_civil_date import epsd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [EPOCH_W-1:0]  epoch_seconds,
  output logic                     done,
  output logic      [YEAR_W-1:0]   year,
  output logic      [MONTH_W-1:0]  month,
  output logic      [DAY_W-1:0]    day,
  output logic      [HOUR_W-1:0]   hour,
  output logic      [MINUTE_W-1:0] minute
);

  split_out_t split_out;

  // The pipeline never backs up: accept a transaction in every cycle
  assign busy = 1'b0;

  // Divide into whole days and seconds of day
  epsd_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .epoch_seconds (epoch_seconds),
    .split_out     (split_out)
  );

  // Days to year, month and day through 400-year eras
  epsd_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_out.valid),
    .days      (split_out.days),
    .out_valid (done),
    .year      (year),
    .month     (month),
    .day       (day)
  );

  // Seconds of day to hour and minute, delayed to line up with the date
  epsd_tod u_tod (
    .clk    (clk),
    .sod    (split_out.sod),
    .hour   (hour),
    .minute (minute)
  );

  // Every accepted transaction strobes done after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a transaction");

  // Reciprocal divisions keep the date fields in range
  a_date_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= 5'd31))
    else $error("month or day out of range");

  a_time_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23) && (minute <= 6'd59))
    else $error("hour or minute out of range");

endmodule

`default_nettype wire
